/* design/tst_pkg.sv */
package tst_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int TIME_WIDTH_DEF = 48;

   localparam int REQ_W      = 3;
   localparam int SLOT_W     = 4;
   localparam int INTERVAL_W = 32;
   localparam int REPEAT_W   = 17;
   localparam int TAG_W      = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_CREATE = 3'd0,
      REQ_START  = 3'd1,
      REQ_STOP   = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_TICK   = 3'd4
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPLY     = 2'd0,
      KIND_EXPIRY    = 2'd1,
      KIND_TICK_DONE = 2'd2
   } result_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NOT_ALLOC    = 3'd1,
      ST_ALREADY_ARMED = 3'd2,
      ST_NOT_ARMED    = 3'd3,
      ST_TABLE_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CREATE,
      S_SCAN,
      S_EMIT,
      S_DONE
   } state_type;

   // Write enables for the per-slot storage, one per field.
   typedef struct packed {
      logic tag_we;
      logic period_we;
      logic reps_we;
      logic deadline_we;
   } mem_wr_type;

endpackage

/* design/tst_slot_mem.sv */
module tst_slot_mem #(
   parameter int NUM_SLOTS  = tst_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = tst_pkg::TIME_WIDTH_DEF
) (
   input  logic                                     clock,
   input  tst_pkg::mem_wr_type                      wr,
   input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
   input  logic [tst_pkg::TAG_W-1:0]                wr_tag,
   input  logic [tst_pkg::INTERVAL_W-1:0]           wr_period,
   input  logic signed [tst_pkg::REPEAT_W-1:0]      wr_reps,
   input  logic [TIME_WIDTH-1:0]                    wr_deadline,
   input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
   output logic [tst_pkg::TAG_W-1:0]                rd_tag,
   output logic [tst_pkg::INTERVAL_W-1:0]           rd_period,
   output logic signed [tst_pkg::REPEAT_W-1:0]      rd_reps,
   output logic [TIME_WIDTH-1:0]                    rd_deadline
);

   logic [tst_pkg::TAG_W-1:0]           tag_mem      [NUM_SLOTS];
   logic [tst_pkg::INTERVAL_W-1:0]      period_mem   [NUM_SLOTS];
   logic signed [tst_pkg::REPEAT_W-1:0] reps_mem     [NUM_SLOTS];
   logic [TIME_WIDTH-1:0]               deadline_mem [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wr.tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr.period_we) begin
         period_mem[wr_addr] <= wr_period;
      end
      if (wr.reps_we) begin
         reps_mem[wr_addr] <= wr_reps;
      end
      if (wr.deadline_we) begin
         deadline_mem[wr_addr] <= wr_deadline;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag      <= tag_mem[rd_addr];
      rd_period   <= period_mem[rd_addr];
      rd_reps     <= reps_mem[rd_addr];
      rd_deadline <= deadline_mem[rd_addr];
   end

endmodule

/* design/timer_slot_table_with_repeat.sv */
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// request   | start, busy, req_*                      | taken when start & !busy
// result    | rsp_valid, rsp_*                        | each result valid for one cycle, no stall
//
// Start, stop, delete and unknown requests are taken without raising busy; the
// reply shows in the next cycle. Create walks the slots from index 0 for the first
// free one, holding busy until it finds one or reaches the last slot. A tick holds
// busy through two passes: one pass through the slot memory updates deadlines through
// the shared adder, a second pass reads tags for the expiry events, then tick done.
// Reset is synchronous, marks all slots free and unarmed and clears the time counter; no clearing pass.
module timer_slot_table_with_repeat #(
   parameter int NUM_SLOTS  = tst_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = tst_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tst_pkg::REQ_W-1:0]           req_type,
   input  logic [tst_pkg::SLOT_W-1:0]          req_slot_index,
   input  logic [tst_pkg::INTERVAL_W-1:0]      req_interval_ticks,
   input  logic signed [tst_pkg::REPEAT_W-1:0] req_repeat_count,
   input  logic [tst_pkg::TAG_W-1:0]           req_user_tag,
   output logic                                rsp_valid,
   output logic [tst_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [tst_pkg::SLOT_W-1:0]          rsp_slot_out,
   output logic [tst_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tst_pkg::TAG_W-1:0]           rsp_tag_out,
   output logic [tst_pkg::COUNT_W-1:0]         rsp_allocated_count,
   output logic [tst_pkg::COUNT_W-1:0]         rsp_active_count,
   output logic                                rsp_last
);

   localparam int IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CntW  = $clog2(NUM_SLOTS + 1);
   localparam int ScanW = IdxW + 1;
   localparam logic [ScanW-1:0] ScanEnd  = ScanW'(NUM_SLOTS);
   localparam logic [ScanW-1:0] ScanLast = ScanW'(NUM_SLOTS - 1);

   tst_pkg::state_type state_ff, state_in;
   logic [ScanW-1:0]   scan_ff, scan_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [IdxW-1:0]    ev_idx_ff, ev_idx_in;
   logic [NUM_SLOTS-1:0] fired_ff, fired_in;
   logic [NUM_SLOTS-1:0] alloc_ff, alloc_in;
   logic [NUM_SLOTS-1:0] armed_ff, armed_in;
   logic [CntW-1:0]    alloc_cnt_ff, alloc_cnt_in;
   logic [CntW-1:0]    act_cnt_ff, act_cnt_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [tst_pkg::TAG_W-1:0] tag_hold_ff, tag_hold_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tst_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [tst_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [tst_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [tst_pkg::TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic [tst_pkg::COUNT_W-1:0]      rsp_alloc_ff, rsp_alloc_in;
   logic [tst_pkg::COUNT_W-1:0]      rsp_act_ff, rsp_act_in;
   logic                             rsp_last_ff, rsp_last_in;

   tst_pkg::mem_wr_type                 mem_wr;
   logic [IdxW-1:0]                     wr_addr;
   logic signed [tst_pkg::REPEAT_W-1:0] wr_reps;
   logic [IdxW-1:0]                     rd_addr;
   logic [tst_pkg::TAG_W-1:0]           rd_tag;
   logic [tst_pkg::INTERVAL_W-1:0]      rd_period;
   logic signed [tst_pkg::REPEAT_W-1:0] rd_reps;
   logic [TIME_WIDTH-1:0]               rd_deadline;

   logic [TIME_WIDTH-1:0] add_b;
   logic [TIME_WIDTH-1:0] add_sum;
   logic                  accept;
   logic                  req_in_range;
   logic [IdxW-1:0]       req_idx;
   logic                  req_alloc;
   logic                  req_armed;
   logic [IdxW-1:0]       scan_idx;

   assign accept       = start && !busy;
   assign busy         = (state_ff != tst_pkg::S_IDLE);
   assign req_in_range = (int'(req_slot_index) < NUM_SLOTS);
   assign req_idx      = IdxW'(req_slot_index);
   assign req_alloc    = req_in_range && alloc_ff[req_idx];
   assign req_armed    = req_in_range && armed_ff[req_idx];
   assign scan_idx     = scan_ff[IdxW-1:0];
   assign rd_addr      = scan_idx;

   // The one adder: tick increment, start deadline and rearm deadline.
   always_comb begin
      if (ev_valid_ff) begin
         add_b = TIME_WIDTH'(rd_period);
      end else if (req_type == tst_pkg::REQ_TICK) begin
         add_b = TIME_WIDTH'(1);
      end else begin
         add_b = TIME_WIDTH'(req_interval_ticks);
      end
   end
   assign add_sum = now_ff + add_b;

   tst_slot_mem #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_mem (
      .clock       (clock),
      .wr          (mem_wr),
      .wr_addr     (wr_addr),
      .wr_tag      (tag_hold_ff),
      .wr_period   (req_interval_ticks),
      .wr_reps     (wr_reps),
      .wr_deadline (add_sum),
      .rd_addr     (rd_addr),
      .rd_tag      (rd_tag),
      .rd_period   (rd_period),
      .rd_reps     (rd_reps),
      .rd_deadline (rd_deadline)
   );

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      ev_valid_in   = 1'b0;
      ev_idx_in     = ev_idx_ff;
      fired_in      = fired_ff;
      alloc_in      = alloc_ff;
      armed_in      = armed_ff;
      alloc_cnt_in  = alloc_cnt_ff;
      act_cnt_in    = act_cnt_ff;
      now_in        = now_ff;
      tag_hold_in   = tag_hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr        = '0;
      wr_addr       = req_idx;
      wr_reps       = req_repeat_count;

      case (state_ff)
         tst_pkg::S_IDLE: begin
            if (accept) begin
               rsp_kind_in = tst_pkg::KIND_REPLY;
               rsp_slot_in = req_slot_index;
               rsp_tag_in  = '0;
               rsp_last_in = 1'b1;
               case (req_type)
                  tst_pkg::REQ_CREATE: begin
                     tag_hold_in = req_user_tag;
                     scan_in     = '0;
                     state_in    = tst_pkg::S_CREATE;
                  end
                  tst_pkg::REQ_START: begin
                     rsp_valid_in = 1'b1;
                     if (!req_alloc) begin
                        rsp_status_in = tst_pkg::ST_NOT_ALLOC;
                     end else if (req_armed) begin
                        rsp_status_in = tst_pkg::ST_ALREADY_ARMED;
                     end else begin
                        rsp_status_in      = tst_pkg::ST_OK;
                        mem_wr.period_we   = 1'b1;
                        mem_wr.reps_we     = 1'b1;
                        mem_wr.deadline_we = 1'b1;
                        armed_in[req_idx]  = 1'b1;
                        act_cnt_in         = act_cnt_ff + CntW'(1);
                     end
                  end
                  tst_pkg::REQ_STOP: begin
                     rsp_valid_in = 1'b1;
                     if (!req_alloc) begin
                        rsp_status_in = tst_pkg::ST_NOT_ALLOC;
                     end else if (!req_armed) begin
                        rsp_status_in = tst_pkg::ST_NOT_ARMED;
                     end else begin
                        rsp_status_in     = tst_pkg::ST_OK;
                        armed_in[req_idx] = 1'b0;
                        act_cnt_in        = act_cnt_ff - CntW'(1);
                     end
                  end
                  tst_pkg::REQ_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (!req_alloc) begin
                        rsp_status_in = tst_pkg::ST_NOT_ALLOC;
                     end else begin
                        rsp_status_in     = tst_pkg::ST_OK;
                        alloc_in[req_idx] = 1'b0;
                        armed_in[req_idx] = 1'b0;
                        alloc_cnt_in      = alloc_cnt_ff - CntW'(1);
                        if (req_armed) begin
                           act_cnt_in = act_cnt_ff - CntW'(1);
                        end
                     end
                  end
                  tst_pkg::REQ_TICK: begin
                     now_in   = add_sum;
                     fired_in = '0;
                     scan_in  = '0;
                     state_in = tst_pkg::S_SCAN;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = tst_pkg::ST_OK;
                  end
               endcase
            end
         end

         tst_pkg::S_CREATE: begin
            wr_addr = scan_idx;
            if (!alloc_ff[scan_idx]) begin
               mem_wr.tag_we      = 1'b1;
               alloc_in[scan_idx] = 1'b1;
               armed_in[scan_idx] = 1'b0;
               alloc_cnt_in       = alloc_cnt_ff + CntW'(1);
               rsp_valid_in       = 1'b1;
               rsp_slot_in        = tst_pkg::SLOT_W'(scan_idx);
               rsp_status_in      = tst_pkg::ST_OK;
               state_in           = tst_pkg::S_IDLE;
            end else if (scan_ff == ScanLast) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_status_in = tst_pkg::ST_TABLE_FULL;
               state_in      = tst_pkg::S_IDLE;
            end else begin
               scan_in = scan_ff + ScanW'(1);
            end
         end

         tst_pkg::S_SCAN: begin
            wr_addr = ev_idx_ff;
            if (scan_ff != ScanEnd) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = scan_idx;
               scan_in     = scan_ff + ScanW'(1);
            end else begin
               scan_in  = '0;
               state_in = tst_pkg::S_EMIT;
            end
            // The slot read in the previous cycle is checked and updated here.
            if (ev_valid_ff && armed_ff[ev_idx_ff] && (rd_deadline <= now_ff)) begin
               fired_in[ev_idx_ff] = 1'b1;
               if (rd_reps != '0) begin
                  mem_wr.deadline_we = 1'b1;
                  wr_reps            = rd_reps - tst_pkg::REPEAT_W'(1);
                  mem_wr.reps_we     = !rd_reps[tst_pkg::REPEAT_W-1];
               end else begin
                  armed_in[ev_idx_ff] = 1'b0;
                  act_cnt_in          = act_cnt_ff - CntW'(1);
               end
            end
         end

         tst_pkg::S_EMIT: begin
            if (scan_ff != ScanEnd) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = scan_idx;
               scan_in     = scan_ff + ScanW'(1);
            end else begin
               scan_in  = '0;
               state_in = tst_pkg::S_DONE;
            end
            if (ev_valid_ff && fired_ff[ev_idx_ff]) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = tst_pkg::KIND_EXPIRY;
               rsp_slot_in   = tst_pkg::SLOT_W'(ev_idx_ff);
               rsp_status_in = tst_pkg::ST_OK;
               rsp_tag_in    = rd_tag;
               rsp_last_in   = 1'b0;
            end
         end

         tst_pkg::S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = tst_pkg::KIND_TICK_DONE;
            rsp_slot_in   = '0;
            rsp_status_in = tst_pkg::ST_OK;
            rsp_tag_in    = '0;
            rsp_last_in   = 1'b1;
            state_in      = tst_pkg::S_IDLE;
         end

         default: begin
            state_in = tst_pkg::S_IDLE;
         end
      endcase

      // Counts are final before the first result of a transaction goes out.
      rsp_alloc_in = tst_pkg::COUNT_W'(alloc_cnt_in);
      rsp_act_in   = tst_pkg::COUNT_W'(act_cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tst_pkg::S_IDLE;
         scan_ff      <= '0;
         ev_valid_ff  <= 1'b0;
         fired_ff     <= '0;
         alloc_ff     <= '0;
         armed_ff     <= '0;
         alloc_cnt_ff <= '0;
         act_cnt_ff   <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         ev_valid_ff  <= ev_valid_in;
         fired_ff     <= fired_in;
         alloc_ff     <= alloc_in;
         armed_ff     <= armed_in;
         alloc_cnt_ff <= alloc_cnt_in;
         act_cnt_ff   <= act_cnt_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      tag_hold_ff   <= tag_hold_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_slot_out        = rsp_slot_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_tag_out         = rsp_tag_ff;
   assign rsp_allocated_count = rsp_alloc_ff;
   assign rsp_active_count    = rsp_act_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

/* design/tst_checker.sv */
module tst_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [tst_pkg::REQ_W-1:0]           req_type,
   input logic                                rsp_valid,
   input logic [tst_pkg::KIND_W-1:0]          rsp_result_kind,
   input logic [tst_pkg::STATUS_W-1:0]        rsp_status,
   input logic [tst_pkg::TAG_W-1:0]           rsp_tag_out,
   input logic [tst_pkg::COUNT_W-1:0]         rsp_allocated_count,
   input logic [tst_pkg::COUNT_W-1:0]         rsp_active_count,
   input logic                                rsp_last
);

   // A tick transaction always keeps the block busy while it scans.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == tst_pkg::REQ_TICK) |=> busy)
      else $error("tick accepted without going busy");

   // Start, stop and delete answer with a single final reply in the next cycle.
   a_quick_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == tst_pkg::REQ_START || req_type == tst_pkg::REQ_STOP
                          || req_type == tst_pkg::REQ_DELETE))
      |=> (rsp_valid && rsp_last && rsp_result_kind == tst_pkg::KIND_REPLY))
      else $error("missing reply after a one-slot request");

   // Expiry events are never final and carry status ok.
   a_expiry_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == tst_pkg::KIND_EXPIRY)
      |-> (!rsp_last && rsp_status == tst_pkg::ST_OK))
      else $error("malformed expiry event");

   // The final result of a transaction coincides with the block being free.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final result shown while still busy");

   // Only allocated slots can be armed, and tags only ride on expiry events.
   a_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid) |-> (rsp_active_count <= rsp_allocated_count
                       && (rsp_result_kind == tst_pkg::KIND_EXPIRY || rsp_tag_out == '0)))
      else $error("inconsistent counts or stray tag");

endmodule

bind timer_slot_table_with_repeat tst_checker u_tst_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import tst_pkg::*;

   localparam int N_SLOTS        = NUM_SLOTS_DEF;
   localparam int TIME_W         = TIME_WIDTH_DEF;
   localparam int TICK_CYCLES    = 2 * N_SLOTS + 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 125;
   localparam int CALM_TAIL      = 30;
   localparam int REPORT_LIMIT   = 10;

   // Request codes outside the defined set; the block must answer them with a plain reply.
   localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

   typedef struct packed {
      logic [REQ_W-1:0]             code;
      logic [SLOT_W-1:0]            slot;
      logic [INTERVAL_W-1:0]        interval;
      logic signed [REPEAT_W-1:0]   repeats;
      logic [TAG_W-1:0]             tag;
   } timer_req_type;

   typedef struct packed {
      result_kind_type              kind;
      logic [SLOT_W-1:0]            slot;
      status_type                   status;
      logic [TAG_W-1:0]             tag;
      logic [COUNT_W-1:0]           n_alloc;
      logic [COUNT_W-1:0]           n_armed;
      logic                         last;
   } timer_rsp_type;

   typedef struct {
      timer_req_type  item;
      int             copies;
      bit             typed;
      timer_rsp_type  reply;
   } plan_row_type;

   logic                         clock              = 1'b0;
   logic                         reset              = 1'b1;
   logic                         start              = 1'b0;
   logic                         busy;
   logic [REQ_W-1:0]             req_type           = '0;
   logic [SLOT_W-1:0]            req_slot_index     = '0;
   logic [INTERVAL_W-1:0]        req_interval_ticks = '0;
   logic signed [REPEAT_W-1:0]   req_repeat_count   = '0;
   logic [TAG_W-1:0]             req_user_tag       = '0;
   logic                         rsp_valid;
   logic [KIND_W-1:0]            rsp_result_kind;
   logic [SLOT_W-1:0]            rsp_slot_out;
   logic [STATUS_W-1:0]          rsp_status;
   logic [TAG_W-1:0]             rsp_tag_out;
   logic [COUNT_W-1:0]           rsp_allocated_count;
   logic [COUNT_W-1:0]           rsp_active_count;
   logic                         rsp_last;

   // Shadow copy of the timer table.
   logic                         slot_used     [N_SLOTS];
   logic                         slot_armed    [N_SLOTS];
   logic [INTERVAL_W-1:0]        slot_period   [N_SLOTS];
   logic signed [REPEAT_W-1:0]   slot_reps     [N_SLOTS];
   logic [TIME_W-1:0]            slot_deadline [N_SLOTS];
   logic [TAG_W-1:0]             slot_tag      [N_SLOTS];
   logic [TIME_W-1:0]            now_ticks;

   timer_rsp_type  step_events[$];
   timer_rsp_type  pending_events[$];
   plan_row_type   plan[$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  random_sent    = 0;
   bit  calm           = 1'b0;

   timer_slot_table_with_repeat #(
      .NUM_SLOTS  (N_SLOTS),
      .TIME_WIDTH (TIME_W)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_slot_index      (req_slot_index),
      .req_interval_ticks  (req_interval_ticks),
      .req_repeat_count    (req_repeat_count),
      .req_user_tag        (req_user_tag),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_slot_out        (rsp_slot_out),
      .rsp_status          (rsp_status),
      .rsp_tag_out         (rsp_tag_out),
      .rsp_allocated_count (rsp_allocated_count),
      .rsp_active_count    (rsp_active_count),
      .rsp_last            (rsp_last)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < N_SLOTS; i++) begin
         slot_used[i]     = 1'b0;
         slot_armed[i]    = 1'b0;
         slot_period[i]   = '0;
         slot_reps[i]     = '0;
         slot_deadline[i] = '0;
         slot_tag[i]      = '0;
      end
      now_ticks = '0;
   end

   function automatic timer_req_type make_req(logic [REQ_W-1:0] code, logic [SLOT_W-1:0] slot,
                                              logic [INTERVAL_W-1:0] interval,
                                              logic signed [REPEAT_W-1:0] repeats,
                                              logic [TAG_W-1:0] tag);
      timer_req_type it;
      it.code     = code;
      it.slot     = slot;
      it.interval = interval;
      it.repeats  = repeats;
      it.tag      = tag;
      return it;
   endfunction

   function automatic void push_event(result_kind_type kind, logic [SLOT_W-1:0] slot,
                                      status_type st, logic [TAG_W-1:0] tag);
      timer_rsp_type r;
      r        = '0;
      r.kind   = kind;
      r.slot   = slot;
      r.status = st;
      r.tag    = tag;
      step_events.push_back(r);
   endfunction

   // Applies one request to the shadow table and lists the results it causes.
   function automatic void predict_request(timer_req_type it);
      int          free_slot;
      int          n_used;
      int          n_armed;
      status_type  st;
      step_events.delete();
      st = ST_OK;
      case (it.code)
         REQ_CREATE: begin
            free_slot = -1;
            for (int i = N_SLOTS - 1; i >= 0; i--)
               if (!slot_used[i]) free_slot = i;
            if (free_slot >= 0) begin
               slot_used[free_slot]  = 1'b1;
               slot_armed[free_slot] = 1'b0;
               slot_tag[free_slot]   = it.tag;
               push_event(KIND_REPLY, SLOT_W'(free_slot), ST_OK, '0);
            end else begin
               push_event(KIND_REPLY, '0, ST_TABLE_FULL, '0);
            end
         end
         REQ_START: begin
            if (!slot_used[it.slot]) begin
               st = ST_NOT_ALLOC;
            end else if (slot_armed[it.slot]) begin
               st = ST_ALREADY_ARMED;
            end else begin
               slot_period[it.slot]   = it.interval;
               slot_reps[it.slot]     = it.repeats;
               slot_deadline[it.slot] = now_ticks + TIME_W'(it.interval);
               slot_armed[it.slot]    = 1'b1;
            end
            push_event(KIND_REPLY, it.slot, st, '0);
         end
         REQ_STOP: begin
            if (!slot_used[it.slot]) st = ST_NOT_ALLOC;
            else if (!slot_armed[it.slot]) st = ST_NOT_ARMED;
            else slot_armed[it.slot] = 1'b0;
            push_event(KIND_REPLY, it.slot, st, '0);
         end
         REQ_DELETE: begin
            if (!slot_used[it.slot]) begin
               st = ST_NOT_ALLOC;
            end else begin
               slot_used[it.slot]  = 1'b0;
               slot_armed[it.slot] = 1'b0;
            end
            push_event(KIND_REPLY, it.slot, st, '0);
         end
         REQ_TICK: begin
            now_ticks = now_ticks + 1'b1;
            for (int i = 0; i < N_SLOTS; i++) begin
               if (slot_armed[i] && slot_deadline[i] <= now_ticks) begin
                  push_event(KIND_EXPIRY, SLOT_W'(i), ST_OK, slot_tag[i]);
                  // A negative count repeats forever and is never decremented.
                  if (slot_reps[i] != 0) begin
                     if (slot_reps[i] > 0) slot_reps[i] = slot_reps[i] - 1'b1;
                     slot_deadline[i] = now_ticks + TIME_W'(slot_period[i]);
                  end else begin
                     slot_armed[i] = 1'b0;
                  end
               end
            end
            push_event(KIND_TICK_DONE, '0, ST_OK, '0);
         end
         default: push_event(KIND_REPLY, it.slot, ST_OK, '0);
      endcase
      n_used  = 0;
      n_armed = 0;
      for (int i = 0; i < N_SLOTS; i++) begin
         n_used  += slot_used[i];
         n_armed += slot_armed[i];
      end
      foreach (step_events[k]) begin
         step_events[k].n_alloc = COUNT_W'(n_used);
         step_events[k].n_armed = COUNT_W'(n_armed);
         step_events[k].last    = (k == step_events.size() - 1);
      end
   endfunction

   function automatic int used_slots();
      int n;
      n = 0;
      for (int i = 0; i < N_SLOTS; i++) n += slot_used[i];
      return n;
   endfunction

   // Mostly aims at a slot in the state the request needs, so most requests succeed.
   function automatic logic [SLOT_W-1:0] pick_slot(logic [REQ_W-1:0] code);
      int  base;
      int  s;
      bit  fits;
      base = $urandom_range(0, N_SLOTS - 1);
      if ($urandom_range(0, 7) == 0) return SLOT_W'(base);
      for (int k = 0; k < N_SLOTS; k++) begin
         s = (base + k) % N_SLOTS;
         case (code)
            REQ_START:  fits = slot_used[s] && !slot_armed[s];
            REQ_STOP:   fits = slot_armed[s];
            REQ_DELETE: fits = slot_used[s];
            default:    fits = 1'b1;
         endcase
         if (fits) return SLOT_W'(s);
      end
      return SLOT_W'(base);
   endfunction

   function automatic logic signed [REPEAT_W-1:0] pick_repeats();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return '0;
      if (roll < 7) return REPEAT_W'($urandom_range(1, 3));
      if (roll < 9) return REPEAT_W'(-1);
      return REPEAT_W'($urandom_range(0, 65535));
   endfunction

   function automatic timer_req_type random_request();
      int                     roll;
      logic [REQ_W-1:0]       code;
      logic [INTERVAL_W-1:0]  interval;
      roll = $urandom_range(0, 99);
      if (roll < 15)      code = REQ_CREATE;
      else if (roll < 40) code = REQ_START;
      else if (roll < 50) code = REQ_STOP;
      else if (roll < 62) code = REQ_DELETE;
      else if (roll < 95) code = REQ_TICK;
      else                code = REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      interval = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
      return make_req(code, pick_slot(code), interval, pick_repeats(), $urandom);
   endfunction

   function automatic int next_gap();
      if (calm || random_sent >= RANDOM_ITEMS - CALM_TAIL) return 0;
      if ($urandom_range(0, 2) != 0) return 0;
      return $urandom_range(1, 16);
   endfunction

   task automatic add_row(logic [REQ_W-1:0] code, logic [SLOT_W-1:0] slot,
                          logic [INTERVAL_W-1:0] interval, logic signed [REPEAT_W-1:0] repeats,
                          logic [TAG_W-1:0] tag, int copies, bit typed = 1'b0,
                          result_kind_type kind = KIND_REPLY, logic [SLOT_W-1:0] rslot = '0,
                          status_type st = ST_OK, int n_alloc = 0, int n_armed = 0);
      plan_row_type row;
      row.item          = make_req(code, slot, interval, repeats, tag);
      row.copies        = copies;
      row.typed         = typed;
      row.reply         = '0;
      row.reply.kind    = kind;
      row.reply.slot    = rslot;
      row.reply.status  = st;
      row.reply.n_alloc = COUNT_W'(n_alloc);
      row.reply.n_armed = COUNT_W'(n_armed);
      row.reply.last    = 1'b1;
      plan.push_back(row);
   endtask

   // Presents one transaction and holds it until the block takes it.
   task automatic issue(timer_req_type it, int gap, bit typed, timer_rsp_type reply);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_type           <= it.code;
      req_slot_index     <= it.slot;
      req_interval_ticks <= it.interval;
      req_repeat_count   <= it.repeats;
      req_user_tag       <= it.tag;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      predict_request(it);
      if (typed) pending_events.push_back(reply);
      else foreach (step_events[k]) pending_events.push_back(step_events[k]);
   endtask

   task automatic send(timer_req_type it);
      issue(it, next_gap(), 1'b0, '0);
      random_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   function automatic string describe(timer_rsp_type r);
      return $sformatf("kind %0d slot %0d status %0d tag %h alloc %0d armed %0d last %0d",
                       r.kind, r.slot, r.status, r.tag, r.n_alloc, r.n_armed, r.last);
   endfunction

   always @(posedge clock) begin : result_check
      timer_rsp_type seen;
      timer_rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            seen.kind    = result_kind_type'(rsp_result_kind);
            seen.slot    = rsp_slot_out;
            seen.status  = status_type'(rsp_status);
            seen.tag     = rsp_tag_out;
            seen.n_alloc = rsp_allocated_count;
            seen.n_armed = rsp_active_count;
            seen.last    = rsp_last;
            if (pending_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: %s", describe(seen));
            end else begin
               want = pending_events.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected %s", describe(want));
                     $display("          actual   %s", describe(seen));
                  end
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      timer_req_type it;
      // Error replies on an empty table, then the unknown request codes and an empty tick.
      add_row(REQ_START, 0, 0, 0, 0, 1, 1, KIND_REPLY, 0, ST_NOT_ALLOC, 0, 0);
      add_row(REQ_STOP, 15, 0, 0, 0, 1, 1, KIND_REPLY, 15, ST_NOT_ALLOC, 0, 0);
      add_row(REQ_DELETE, 3, 0, 0, 0, 1, 1, KIND_REPLY, 3, ST_NOT_ALLOC, 0, 0);
      add_row(REQ_UNKNOWN_LO, 9, 0, 0, 0, 1, 1, KIND_REPLY, 9, ST_OK, 0, 0);
      add_row(REQ_UNKNOWN_HI, 15, 0, 0, 0, 1, 1, KIND_REPLY, 15, ST_OK, 0, 0);
      add_row(REQ_TICK, 0, 0, 0, 0, 1, 1, KIND_TICK_DONE, 0, ST_OK, 0, 0);
      // Fill the table; the tags step across the wrap from all ones to zero.
      add_row(REQ_CREATE, 0, 0, 0, 32'hFFFF_FFF8, N_SLOTS);
      add_row(REQ_CREATE, 0, 0, 0, 32'h5A5A_A5A5, 1, 1, KIND_REPLY, 0, ST_TABLE_FULL,
              N_SLOTS, 0);
      add_row(REQ_STOP, 0, 0, 0, 0, 1, 1, KIND_REPLY, 0, ST_NOT_ARMED, N_SLOTS, 0);
      add_row(REQ_START, 0, 0, 0, 0, 1, 1, KIND_REPLY, 0, ST_OK, N_SLOTS, 1);
      add_row(REQ_START, 0, 5, 2, 0, 1, 1, KIND_REPLY, 0, ST_ALREADY_ARMED, N_SLOTS, 1);
      add_row(REQ_START, 1, 1, -1, 0, 1, 1, KIND_REPLY, 1, ST_OK, N_SLOTS, 2);
      add_row(REQ_START, 2, 32'hFFFF_FFFF, 65535, 0, 1, 1, KIND_REPLY, 2, ST_OK, N_SLOTS, 3);
      add_row(REQ_START, 3, 2, 1, 0, 1, 1, KIND_REPLY, 3, ST_OK, N_SLOTS, 4);
      add_row(REQ_TICK, 0, 0, 0, 0, 3);
      add_row(REQ_STOP, 1, 0, 0, 0, 1);
      add_row(REQ_DELETE, 2, 0, 0, 0, 1);
      add_row(REQ_DELETE, 3, 0, 0, 0, 1);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (int c = 0; c < plan[r].copies; c++) begin
            it      = plan[r].item;
            it.slot = SLOT_W'(it.slot + c);
            it.tag  = TAG_W'(it.tag + c);
            issue(it, next_gap(), plan[r].typed, plan[r].reply);
         end
      end
      wait_drained();

      while (random_sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // Fill the table, arm every idle slot with a short interval and tick, so that
            // ticks can reach a full burst of expiry events.
            while (used_slots() < N_SLOTS)
               send(make_req(REQ_CREATE, pick_slot(REQ_CREATE), 0, 0, $urandom));
            send(make_req(REQ_CREATE, 0, 0, 0, $urandom));
            for (int s = 0; s < N_SLOTS; s++)
               if (!slot_armed[s])
                  send(make_req(REQ_START, SLOT_W'(s), $urandom_range(0, 3), pick_repeats(),
                                $urandom));
            repeat ($urandom_range(3, 8)) send(make_req(REQ_TICK, 0, 0, 0, 0));
         end else begin
            repeat (10) send(random_request());
         end
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      wait_drained();
      repeat (TICK_CYCLES + 5) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
